// File: rtl/core/ohlcv_pkg.sv
// Shared widths, reset values and configuration register indexes for the OHLCV bar aggregator.
`default_nettype none

package ohlcv_pkg;

    localparam int QTY_W    = 32;
    localparam int STAMP_W  = 63;
    localparam int VOLUME_W = 64;
    localparam int COUNT_W  = 32;
    localparam int TOTAL_W  = 64;
    localparam int ALPHA_W  = 16;
    localparam int CFG_W    = 63;

    localparam logic [STAMP_W-1:0] DURATION_RESET = 63'd1000000000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 16'd6554;

    typedef enum logic [0:0] {
        CFG_BAR_DURATION = 1'b0,
        CFG_EMA_ALPHA    = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

// File: rtl/core/ohlcv_bar_track.sv
// Running bar state: open, high, low, close, volume, tick count and bar close detection.
`default_nettype none

module ohlcv_bar_track #(
    parameter int PRICE_WIDTH = 48
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [PRICE_WIDTH-1:0]        i_price,
    input  wire logic [ohlcv_pkg::QTY_W-1:0]   i_qty,
    input  wire logic [ohlcv_pkg::STAMP_W-1:0] i_stamp,
    input  wire logic [ohlcv_pkg::STAMP_W-1:0] i_duration,
    output logic                               o_done,
    output logic [PRICE_WIDTH-1:0]             o_open,
    output logic [PRICE_WIDTH-1:0]             o_high,
    output logic [PRICE_WIDTH-1:0]             o_low,
    output logic [PRICE_WIDTH-1:0]             o_close,
    output logic [ohlcv_pkg::VOLUME_W-1:0]     o_volume,
    output logic [ohlcv_pkg::COUNT_W-1:0]      o_ticks
);

    logic [PRICE_WIDTH-1:0]             r_open, r_high, r_low, r_close;
    logic [PRICE_WIDTH-1:0]             n_open, n_high, n_low, n_close;
    logic [ohlcv_pkg::VOLUME_W-1:0]     r_volume, n_volume;
    logic [ohlcv_pkg::COUNT_W-1:0]      r_count, n_count;
    logic [ohlcv_pkg::STAMP_W-1:0]      r_start, n_start;

    logic                               first;
    logic                               closing;
    logic                               restart;
    logic [ohlcv_pkg::STAMP_W-1:0]      dur;
    logic [ohlcv_pkg::STAMP_W-1:0]      elapsed;
    logic [PRICE_WIDTH-1:0]             base_high, base_low;
    logic [ohlcv_pkg::VOLUME_W-1:0]     base_volume;
    logic [ohlcv_pkg::COUNT_W-1:0]      base_count;
    logic [ohlcv_pkg::VOLUME_W:0]       volume_sum;

    always_comb begin
        first   = (r_count == '0);
        dur     = (i_duration == '0) ? ohlcv_pkg::STAMP_W'(1) : i_duration;
        elapsed = i_stamp - r_start;
        // A stamp earlier than the bar start never closes the bar.
        closing = !first && (i_stamp >= r_start) && (elapsed >= dur);
        restart = first || closing;

        base_high   = restart ? i_price : r_high;
        base_low    = restart ? i_price : r_low;
        base_volume = restart ? '0 : r_volume;
        base_count  = restart ? '0 : r_count;

        n_open  = restart ? i_price : r_open;
        n_high  = (i_price > base_high) ? i_price : base_high;
        n_low   = (i_price < base_low) ? i_price : base_low;
        n_close = i_price;
        n_start = restart ? i_stamp : r_start;

        volume_sum = {1'b0, base_volume} + (ohlcv_pkg::VOLUME_W + 1)'(i_qty);
        n_volume   = volume_sum[ohlcv_pkg::VOLUME_W] ? '1
                                                     : volume_sum[ohlcv_pkg::VOLUME_W-1:0];
        n_count    = (base_count == '1) ? base_count : base_count + 1'b1;

        // The closed bar is reported from the state as it stood before this tick.
        o_done   = closing;
        o_open   = closing ? r_open   : '0;
        o_high   = closing ? r_high   : '0;
        o_low    = closing ? r_low    : '0;
        o_close  = closing ? r_close  : '0;
        o_volume = closing ? r_volume : '0;
        o_ticks  = closing ? r_count  : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= '0;
            r_high   <= '0;
            r_low    <= '0;
            r_close  <= '0;
            r_volume <= '0;
            r_count  <= '0;
            r_start  <= '0;
        end else if (i_step) begin
            r_open   <= n_open;
            r_high   <= n_high;
            r_low    <= n_low;
            r_close  <= n_close;
            r_volume <= n_volume;
            r_count  <= n_count;
            r_start  <= n_start;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ohlcv_ema_unit.sv
// Exponential moving average of the price with a floored fixed point step and clamping.
`default_nettype none

module ohlcv_ema_unit #(
    parameter int PRICE_WIDTH     = 48,
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [PRICE_WIDTH-1:0]        i_price,
    input  wire logic [ohlcv_pkg::ALPHA_W-1:0] i_alpha,
    output logic [PRICE_WIDTH-1:0]             o_ema
);

    localparam int PROD_W = PRICE_WIDTH + ohlcv_pkg::ALPHA_W;
    localparam int EXT_W  = PROD_W + 1;

    logic                    r_valid;
    logic [PRICE_WIDTH-1:0]  r_ema, n_ema;

    logic                    rising;
    logic [PRICE_WIDTH-1:0]  diff;
    logic [PROD_W-1:0]       prod;
    logic [EXT_W-1:0]        ema_ext;
    logic [EXT_W-1:0]        step_dn;
    logic [EXT_W-1:0]        step_up;
    logic [EXT_W-1:0]        sum_up;

    always_comb begin
        rising  = (i_price >= r_ema);
        diff    = rising ? (i_price - r_ema) : (r_ema - i_price);
        prod    = PROD_W'(diff) * PROD_W'(i_alpha);
        ema_ext = EXT_W'(r_ema);
        // Upward steps round down, downward steps round up: together a floor.
        step_dn = EXT_W'(prod) >> ALPHA_FRAC_BITS;
        step_up = (EXT_W'(prod) + EXT_W'({ALPHA_FRAC_BITS{1'b1}})) >> ALPHA_FRAC_BITS;
        sum_up  = ema_ext + step_dn;

        if (!r_valid) begin
            n_ema = i_price;
        end else if (rising) begin
            n_ema = (sum_up > EXT_W'({PRICE_WIDTH{1'b1}})) ? '1
                                                           : sum_up[PRICE_WIDTH-1:0];
        end else begin
            n_ema = (step_up >= ema_ext) ? '0 : r_ema - step_up[PRICE_WIDTH-1:0];
        end
        o_ema = n_ema;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ema   <= '0;
        end else if (i_step) begin
            r_valid <= 1'b1;
            r_ema   <= n_ema;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ohlcv_bar_ema_aggregator.sv
// Top level of the OHLCV bar aggregator with moving average: streams, registers and counters.
`default_nettype none

// Each trade tick request carries a Q32.16 price, a quantity and a nanosecond stamp, and gives
// exactly one result request. A tick lands in an input register; once the output register is
// free, the bar and average state are updated from it and the result is loaded into the output
// register, from which it is presented. A new tick is taken every cycle while the output side
// keeps up. The rate is set by the combinational state update (bar compare and the
// price-difference by alpha multiply feeding the average). The first tick opens a bar; a
// later tick whose stamp is at least bar_duration after the bar start closes it, and the
// closed bar is reported with tuser set while the new bar starts with that tick. Every result
// also carries the updated average and the saturating count of all ticks seen. Configuration
// must be written only while no request is in flight; the block itself does not enforce it.
// A duration of zero behaves as one.
module ohlcv_bar_ema_aggregator #(
    parameter int PRICE_WIDTH     = 48,
    parameter int ALPHA_FRAC_BITS = 16,
    localparam int IN_BITS        = PRICE_WIDTH + ohlcv_pkg::QTY_W + ohlcv_pkg::STAMP_W,
    localparam int IN_TDATA_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS       = 5 * PRICE_WIDTH + ohlcv_pkg::VOLUME_W
                                    + ohlcv_pkg::COUNT_W + ohlcv_pkg::TOTAL_W,
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Configuration write port.
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [0:0]                  i_cfg_addr,
    input  wire logic [ohlcv_pkg::CFG_W-1:0] i_cfg_wdata,
    // Tick stream in.
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // Fields from bit 0 up: price, quantity, stamp_ns, zero padding.
    input  wire logic [IN_TDATA_W-1:0]       i_s_axis_tdata,
    // Result stream out.
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // Fields from bit 0 up: bar_open, bar_high, bar_low, bar_close, bar_volume, bar_ticks,
    // ema_price, ticks_seen, zero padding.
    output logic [OUT_TDATA_W-1:0]           o_m_axis_tdata,
    // Fields from bit 0 up: bar_done.
    output logic [0:0]                       o_m_axis_tuser
);

    localparam int QTY_LSB   = PRICE_WIDTH;
    localparam int STAMP_LSB = PRICE_WIDTH + ohlcv_pkg::QTY_W;

    // Configuration registers.
    logic [ohlcv_pkg::STAMP_W-1:0] r_duration;
    logic [ohlcv_pkg::ALPHA_W-1:0] r_alpha;

    // Input register.
    logic                          r_in_valid;
    logic [PRICE_WIDTH-1:0]        r_in_price;
    logic [ohlcv_pkg::QTY_W-1:0]   r_in_qty;
    logic [ohlcv_pkg::STAMP_W-1:0] r_in_stamp;

    // Output register.
    logic                          r_out_valid;
    logic [OUT_BITS-1:0]           r_out_data;
    logic                          r_out_done;

    // Running total of ticks.
    logic [ohlcv_pkg::TOTAL_W-1:0] r_total, n_total;

    logic                          out_free;
    logic                          advance;
    logic                          in_take;

    logic                          bar_done;
    logic [PRICE_WIDTH-1:0]        bar_open, bar_high, bar_low, bar_close;
    logic [ohlcv_pkg::VOLUME_W-1:0] bar_volume;
    logic [ohlcv_pkg::COUNT_W-1:0] bar_ticks;
    logic [PRICE_WIDTH-1:0]        ema_price;

    // The output register frees up when it is empty or being drained this cycle; the
    // input register can then hand its tick over, which in turn lets a fresh tick in.
    always_comb begin
        out_free        = !r_out_valid || i_m_axis_tready;
        advance         = r_in_valid && out_free;
        o_s_axis_tready = !r_in_valid || out_free;
        in_take         = i_s_axis_tvalid && o_s_axis_tready;
        n_total         = (r_total == '1) ? r_total : r_total + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= ohlcv_pkg::DURATION_RESET;
            r_alpha    <= ohlcv_pkg::ALPHA_RESET;
        end else if (i_cfg_wr_en) begin
            case (ohlcv_pkg::t_cfg_idx'(i_cfg_addr))
                ohlcv_pkg::CFG_BAR_DURATION: begin
                    r_duration <= i_cfg_wdata;
                end
                ohlcv_pkg::CFG_EMA_ALPHA: begin
                    r_alpha <= i_cfg_wdata[ohlcv_pkg::ALPHA_W-1:0];
                end
                default: begin
                    r_alpha <= r_alpha;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_price <= i_s_axis_tdata[PRICE_WIDTH-1:0];
            r_in_qty   <= i_s_axis_tdata[QTY_LSB +: ohlcv_pkg::QTY_W];
            r_in_stamp <= i_s_axis_tdata[STAMP_LSB +: ohlcv_pkg::STAMP_W];
        end
    end

    ohlcv_bar_track #(
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_bar (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_price    (r_in_price),
        .i_qty      (r_in_qty),
        .i_stamp    (r_in_stamp),
        .i_duration (r_duration),
        .o_done     (bar_done),
        .o_open     (bar_open),
        .o_high     (bar_high),
        .o_low      (bar_low),
        .o_close    (bar_close),
        .o_volume   (bar_volume),
        .o_ticks    (bar_ticks)
    );

    ohlcv_ema_unit #(
        .PRICE_WIDTH     (PRICE_WIDTH),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_ema (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_price (r_in_price),
        .i_alpha (r_alpha),
        .o_ema   (ema_price)
    );

    // The tick total counts saturating and is reported including the current tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_total     <= n_total;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_done <= bar_done;
            r_out_data <= {n_total, ema_price, bar_ticks, bar_volume,
                           bar_close, bar_low, bar_high, bar_open};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_data);
    assign o_m_axis_tuser  = r_out_done;

endmodule

`default_nettype wire

// File: sim/ohlcv_bar_ema_aggregator_tb.sv
// Self-checking testbench for the OHLCV bar aggregator: tick stream in, bar results out.
`default_nettype none

// Ticks are queued by the stimulus process and presented by a clocked driver at the falling
// edge. A monitor at the rising edge predicts one result for every accepted tick request and
// compares each result request against the oldest prediction, field by field. Both sides idle
// at random, with one stretch of no idling and one long hold-off on the result side.
module ohlcv_bar_ema_aggregator_tb;
    import ohlcv_pkg::*;

    localparam int          TICK_W      = 144;
    localparam int          RESULT_W    = 400;
    localparam int          IDLE_PCT    = 22;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_AFTER  = 500;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [47:0] PRICE_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam logic [62:0] STAMP_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] STAMP_CEIL  = 64'h7FF0_0000_0000_0000;
    localparam logic [47:0] ONE_UNIT    = 48'h1_0000;

    // Packed so that price sits in the lowest bits, as on the tick bus.
    typedef struct packed {
        logic [62:0] stamp;
        logic [31:0] qty;
        logic [47:0] price;
    } tick_t;

    typedef struct {
        logic        done;
        logic [47:0] open_px;
        logic [47:0] high_px;
        logic [47:0] low_px;
        logic [47:0] close_px;
        logic [63:0] volume;
        logic [31:0] n_ticks;
        logic [47:0] ema;
        logic [63:0] seen;
    } bar_result_t;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_wr_en     = 1'b0;
    logic [0:0]          i_cfg_addr      = CFG_BAR_DURATION;
    logic [CFG_W-1:0]    i_cfg_wdata     = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic [TICK_W-1:0]   i_s_axis_tdata  = '0;
    logic                i_m_axis_tready = 1'b0;
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [RESULT_W-1:0] o_m_axis_tdata;
    logic [0:0]          o_m_axis_tuser;

    ohlcv_bar_ema_aggregator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    tick_t       pending_ticks[$];
    bar_result_t expected_bars[$];
    int          results_seen = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;
    logic        tick_taken   = 1'b0;
    int          hold_left    = 0;
    logic        hold_done    = 1'b0;

    // Predictor copy of the block's registers and bar state.
    logic [62:0] cfg_duration;
    logic [15:0] cfg_alpha;
    logic [47:0] bar_open_px, bar_high_px, bar_low_px, bar_close_px;
    logic [63:0] bar_vol;
    logic [62:0] bar_t0;
    logic [31:0] bar_n;
    logic [47:0] ema_px;
    logic        ema_seeded;
    logic [63:0] ticks_total;

    // Stimulus generator state: running clock, its view of the bar start, price level.
    logic [63:0] gen_now;
    logic [63:0] gen_start;
    logic [47:0] gen_px;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // No idling on either side while this window of results passes.
    function automatic logic steady();
        return results_seen >= 900 && results_seen < 1100;
    endfunction

    task automatic open_bar(input logic [47:0] price, input logic [62:0] stamp);
        bar_open_px  = price;
        bar_high_px  = price;
        bar_low_px   = price;
        bar_close_px = price;
        bar_vol      = '0;
        bar_t0       = stamp;
        bar_n        = '0;
    endtask

    // Advances the bar and average state by one tick and gives the result it reports.
    task automatic apply_tick(input tick_t tk, output bar_result_t r);
        logic [62:0] dur;
        logic [47:0] diff;
        logic [79:0] prod;
        logic [63:0] step;
        logic [64:0] vsum;
        r = '{default: '0};
        dur = (cfg_duration == '0) ? 63'd1 : cfg_duration;
        if (ticks_total != '1) ticks_total = ticks_total + 1;

        if (bar_n == '0) begin
            open_bar(tk.price, tk.stamp);
        end else if (tk.stamp >= bar_t0 && (tk.stamp - bar_t0) >= dur) begin
            // A tick stamped before the bar start never gets here: it joins the bar.
            r.done     = 1'b1;
            r.open_px  = bar_open_px;
            r.high_px  = bar_high_px;
            r.low_px   = bar_low_px;
            r.close_px = bar_close_px;
            r.volume   = bar_vol;
            r.n_ticks  = bar_n;
            open_bar(tk.price, tk.stamp);
        end

        if (tk.price > bar_high_px) bar_high_px = tk.price;
        if (tk.price < bar_low_px) bar_low_px = tk.price;
        bar_close_px = tk.price;
        vsum = {1'b0, bar_vol} + tk.qty;
        bar_vol = vsum[64] ? '1 : vsum[63:0];
        if (bar_n != '1) bar_n = bar_n + 1;

        // Rising prices step the average by the floored product; falling ones by the
        // product rounded up, which is the floor of the negative step.
        if (!ema_seeded) begin
            ema_px     = tk.price;
            ema_seeded = 1'b1;
        end else if (tk.price >= ema_px) begin
            diff = tk.price - ema_px;
            prod = diff * cfg_alpha;
            step = prod[79:16];
            if (step > {16'b0, PRICE_MAX - ema_px}) ema_px = PRICE_MAX;
            else ema_px = ema_px + step[47:0];
        end else begin
            diff = ema_px - tk.price;
            prod = diff * cfg_alpha;
            step = prod[79:16];
            if (prod[15:0] != '0) step = step + 1;
            if (step >= {16'b0, ema_px}) ema_px = '0;
            else ema_px = ema_px - step[47:0];
        end

        r.ema  = ema_px;
        r.seen = ticks_total;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
        end
    endtask

    // Monitor: result requests are checked, tick requests feed the predictor.
    always @(posedge i_clk) begin
        bar_result_t got, want, predicted;
        tick_t       tk;
        tick_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;

        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            got.done     = o_m_axis_tuser[0];
            got.open_px  = o_m_axis_tdata[47:0];
            got.high_px  = o_m_axis_tdata[95:48];
            got.low_px   = o_m_axis_tdata[143:96];
            got.close_px = o_m_axis_tdata[191:144];
            got.volume   = o_m_axis_tdata[255:192];
            got.n_ticks  = o_m_axis_tdata[287:256];
            got.ema      = o_m_axis_tdata[335:288];
            got.seen     = o_m_axis_tdata[399:336];
            if (expected_bars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with no tick outstanding", results_seen);
            end else begin
                want = expected_bars.pop_front();
                check_field("bar_done", want.done, got.done);
                check_field("bar_open", want.open_px, got.open_px);
                check_field("bar_high", want.high_px, got.high_px);
                check_field("bar_low", want.low_px, got.low_px);
                check_field("bar_close", want.close_px, got.close_px);
                check_field("bar_volume", want.volume, got.volume);
                check_field("bar_ticks", want.n_ticks, got.n_ticks);
                check_field("ema_price", want.ema, got.ema);
                check_field("ticks_seen", want.seen, got.seen);
            end
        end

        if (tick_taken) begin
            tk = i_s_axis_tdata[TICK_W-2:0];
            apply_tick(tk, predicted);
            expected_bars.push_back(predicted);
        end
    end

    // Driver: a tick stays on the bus until taken, then the next one follows or a gap.
    always @(negedge i_clk) begin
        tick_t nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || tick_taken) begin
            if (pending_ticks.size() != 0 && (steady() || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = pending_ticks.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {1'b0, nxt};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off so that the block backs up and
    // stops taking ticks while the driver keeps offering them.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left       <= HOLD_CYCLES;
            hold_done       <= 1'b1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= steady() || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_tick(input logic [47:0] price, input logic [31:0] qty,
                            input logic [62:0] stamp);
        tick_t tk;
        tk.price = price;
        tk.qty   = qty;
        tk.stamp = stamp;
        pending_ticks.push_back(tk);
    endtask

    // Registers are only touched once every tick has been answered and the pipe is empty.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_s_axis_tvalid || expected_bars.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [62:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_BAR_DURATION) cfg_duration = value;
        else cfg_alpha = value[15:0];
    endtask

    // One random tick: mostly an orderly clock that walks through bars, with some ticks
    // stamped before the bar start and some forward jumps with arbitrary prices.
    task automatic gen_tick(input logic [63:0] dur, input int spread);
        int          kind;
        int          pick;
        logic [63:0] stamp;
        logic [47:0] price;
        logic [31:0] qty;
        logic [47:0] d;
        kind = $urandom_range(99);
        pick = $urandom_range(99);
        d    = $urandom_range(0, spread);

        if ($urandom_range(1)) gen_px = (gen_px > PRICE_MAX - d) ? PRICE_MAX : gen_px + d;
        else gen_px = (gen_px < d) ? '0 : gen_px - d;
        price = gen_px;
        if (pick < 3) price = '0;
        else if (pick < 6) price = PRICE_MAX;

        pick = $urandom_range(99);
        if (pick < 5) qty = '0;
        else if (pick < 10) qty = '1;
        else if (pick < 15) qty = $urandom_range(0, 100);
        else qty = $urandom;

        if (kind < 80) begin
            pick = $urandom_range(99);
            if (pick < 10 && gen_start + dur > gen_now) stamp = gen_start + dur;
            else if (pick < 15 && gen_start + dur - 1 > gen_now) stamp = gen_start + dur - 1;
            else stamp = gen_now + rand64() % (dur / 2 + 1);
        end else if (kind < 90) begin
            stamp = (gen_start == '0) ? gen_now : gen_start - 1 - rand64() % gen_start;
        end else begin
            stamp = gen_now + (rand64() >> $urandom_range(20, 40));
            price = rand64();
        end

        if (kind < 80 || kind >= 90) begin
            gen_now = stamp;
            if (stamp >= gen_start && stamp - gen_start >= dur) gen_start = stamp;
        end
        add_tick(price, qty, stamp[62:0]);
    endtask

    initial begin
        logic [63:0] sess_dur;
        logic [63:0] jump;
        int          spread;
        int          n;

        cfg_duration = DURATION_RESET;
        cfg_alpha    = ALPHA_RESET;
        open_bar('0, '0);
        ema_px      = '0;
        ema_seeded  = 1'b0;
        ticks_total = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset durations and alpha: first tick opens a bar, extremes of price and
        // quantity, a tick one short of the boundary, then exactly on it.
        add_tick(ONE_UNIT, 32'd0, 63'd0);
        add_tick(PRICE_MAX, 32'hFFFF_FFFF, 63'd5);
        add_tick(48'd0, 32'hFFFF_FFFF, 63'd999_999_999);
        add_tick(48'd100 * ONE_UNIT, 32'd1, 63'd1_000_000_000);
        // Stamped before the bar start, so it joins the open bar.
        add_tick(48'd50 * ONE_UNIT, 32'd7, 63'd500);
        add_tick(48'd60 * ONE_UNIT, 32'd3, 63'd1_999_999_999);
        add_tick(48'd61 * ONE_UNIT, 32'd2, 63'd2_000_000_000);
        add_tick(48'h3D_8000, 32'd9, 63'd2_000_000_000);
        wait_drained();

        // A duration of zero acts as one; alpha at its largest value.
        write_reg(CFG_BAR_DURATION, 63'd0);
        write_reg(CFG_EMA_ALPHA, 63'hFFFF);
        add_tick(48'd0, 32'd4, 63'd2_000_000_000);
        add_tick(PRICE_MAX, 32'd5, 63'd2_000_000_001);
        add_tick(48'd0, 32'd6, 63'd2_000_000_002);
        add_tick(48'h12_3456_789A, 32'd8, 63'd2_000_000_001);
        wait_drained();

        // Longest duration: nothing closes; alpha of zero freezes the average.
        write_reg(CFG_BAR_DURATION, STAMP_MAX);
        write_reg(CFG_EMA_ALPHA, 63'd0);
        add_tick(48'h7777_0000, 32'd10, 63'd2_000_000_003);
        add_tick(48'h1, 32'd11, 63'd1 << 40);

        gen_now   = 64'd1 << 40;
        gen_start = 64'd2_000_000_002;
        gen_px    = 48'd100 * ONE_UNIT;

        for (int s = 0; s < 8; s++) begin
            wait_drained();
            n = $urandom_range(99);
            if (s == 0) sess_dur = 64'd1;
            else if (n < 60) sess_dur = $urandom_range(1, 1000);
            else if (n < 90) sess_dur = $urandom_range(1, 1 << 20);
            else sess_dur = (rand64() >> 24) + 1;
            spread = 1 << $urandom_range(4, 30);
            write_reg(CFG_BAR_DURATION, sess_dur[62:0]);
            write_reg(CFG_EMA_ALPHA, $urandom_range(0, 16'hFFFF));

            // Move the clock forward between sessions so the high stamp bits get exercised.
            jump = rand64() >> $urandom_range(3, 12);
            if (gen_now + jump < STAMP_CEIL) gen_now = gen_now + jump;
            if (s == 7) gen_now = gen_now | 64'h4000_0000_0000_0000;
            for (int k = 0; k < 185; k++) gen_tick(sess_dur, spread);
        end
        wait_drained();

        // The largest stamp pins the bar start for good, so it comes last.
        write_reg(CFG_BAR_DURATION, 63'd1000);
        add_tick(48'd42 * ONE_UNIT, 32'd1, STAMP_MAX);
        add_tick(48'd43 * ONE_UNIT, 32'd2, STAMP_MAX);
        add_tick(48'd44 * ONE_UNIT, 32'd3, 63'd0);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && expected_bars.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/ohlcv_pkg.sv
rtl/core/ohlcv_bar_track.sv
rtl/core/ohlcv_ema_unit.sv
rtl/core/ohlcv_bar_ema_aggregator.sv
sim/ohlcv_bar_ema_aggregator_tb.sv
